[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while the block is out of reset.
`define DPBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define DPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dpbp_pkg.sv]
// Types and constants of the depth pixel back-projection block.
`timescale 1ns / 1ps
`default_nettype none

package dpbp_pkg;

  // Image bounds; a pixel at or beyond them gives no point.
  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned MAX_ROWS    = 4096;
  localparam logic [13:0] COL_LIMIT   = 14'(MAX_COLUMNS);
  localparam logic [13:0] ROW_LIMIT   = 14'(MAX_ROWS);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CENTER_COL  = 2'd0,
    CFG_CENTER_ROW  = 2'd1,
    CFG_INV_FOCAL_X = 2'd2,
    CFG_INV_FOCAL_Y = 2'd3
  } cfg_idx_e;

  localparam logic [12:0] CENTER_COL_RST  = 13'd651;
  localparam logic [12:0] CENTER_ROW_RST  = 13'd507;
  localparam logic [31:0] INV_FOCAL_X_RST = 32'd8291444;
  localparam logic [31:0] INV_FOCAL_Y_RST = 32'd8275469;

  // Depth to metres: z = floor((d * 8192 + 62) / 125), done as a multiply by
  // ceil(2^37 / 125) and a shift, exact for every 16-bit depth.
  localparam int unsigned Z_SHIFT = 37;
  localparam int unsigned Z_W     = 23;
  localparam int unsigned ZM_W    = 29;
  localparam int unsigned ZP_W    = ZM_W + 31;
  localparam logic [30:0] Z_RECIP = 31'd1099511628;
  localparam logic [ZM_W-1:0] Z_BIAS = 29'd62;

  // Offset magnitude in half pixels, offset times depth, scaled magnitude.
  localparam int unsigned OFF_W  = 13;
  localparam int unsigned PROD_W = OFF_W + Z_W;
  localparam int unsigned MAG_W  = PROD_W;

  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [11:0] column;
    logic [11:0] pixel_row;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [Z_W-1:0]     point_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
  } point_t;

endpackage

`default_nettype wire

[rtl/dpbp_coord.sv]
// Four-stage datapath that scales one pixel offset by depth and a focal reciprocal.
`timescale 1ns / 1ps
`default_nettype none

module dpbp_coord import dpbp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [OFF_W-1:0]   off_mag_i,
  input  logic               neg_i,
  input  logic [Z_W-1:0]     z_i,
  input  logic [31:0]        inv_i,
  output logic signed [31:0] coord_o
);

  logic [PROD_W-1:0] prod_d, prod_q;
  logic [63:0]       lo_d, lo_q;
  logic [35:0]       hi_d, hi_q;
  logic [MAG_W:0]    sum;
  logic [MAG_W-1:0]  mag_d, mag_q;
  logic [31:0]       coord_d, coord_q;
  logic [2:0]        neg_q;

  assign prod_d = PROD_W'(off_mag_i) * PROD_W'(z_i);

  // The 36-bit product is split so that each multiplier stays 32 bits wide.
  assign lo_d = 64'(prod_q[31:0]) * 64'(inv_i);
  assign hi_d = 36'(prod_q[PROD_W-1:32]) * 36'(inv_i);

  // Adding one at bit 32 and dropping 33 bits rounds half up.
  assign sum   = (MAG_W+1)'(hi_q) + (MAG_W+1)'(lo_q[63:32]) + (MAG_W+1)'(1);
  assign mag_d = sum[MAG_W:1];

  // The sign travels three stages so that it lines up with the rounded magnitude.
  always_comb begin
    coord_d = '0;
    if (mag_q != '0) begin
      if (!neg_q[2]) begin
        coord_d = (mag_q > MAG_W'(COORD_MAX)) ? COORD_MAX : mag_q[31:0];
      end else begin
        coord_d = (mag_q > MAG_W'(COORD_MIN)) ? COORD_MIN : 32'(32'd0 - mag_q[31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mag_q   <= mag_d;
      coord_q <= coord_d;
      neg_q   <= {neg_q[1:0], neg_i};
    end
  end

  assign coord_o = $signed(coord_q);

endmodule

`default_nettype wire

[rtl/depth_pixel_back_projection.sv]
// Top level of the depth pixel back-projection block.
`timescale 1ns / 1ps
`default_nettype none

// Turns a stream of depth pixels into colored 3-D points with a pinhole camera model.
// The block accepts one pixel beat per clock while in_stall_o is low; the output beat
// is valid once the pixel has passed all five register stages. A pixel with zero
// depth, or one outside the image bounds, leaves a bubble and gives no output beat.
// The five register stages are: depth conversion and pixel offsets, offset times
// depth, the two halves of the reciprocal multiply, rounding, and saturation into
// the output register. The whole pipeline advances together and holds while an
// output beat is stalled; in_stall_o is a register that rises in the cycle after a
// beat is accepted during a hold, and that beat is kept in a one-entry skid register.
// The principal point and the focal reciprocals are plain registers written through
// the cfg port; the user must write them only while the block is idle, which the
// block itself does not enforce.
module depth_pixel_back_projection import dpbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pixel_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output point_t      out_data_o
);

  typedef struct packed {
    logic [Z_W-1:0] z;
    logic [7:0]     blue;
    logic [7:0]     green;
    logic [7:0]     red;
  } side_t;

  logic [12:0] center_col_q, center_row_q;
  logic [31:0] inv_focal_x_q, inv_focal_y_q;

  logic   pipe_en;
  logic   skid_v_d, skid_v_q;
  pixel_t skid_q;
  pixel_t src;
  logic   src_v;

  logic [4:0] v_q;
  logic       v_d;
  side_t      side_d;
  side_t      side_q [5];

  logic [ZM_W-1:0]    z_num;
  logic [ZP_W-1:0]    z_prod;
  logic signed [13:0] dc, dr;
  logic [13:0]        dc_neg, dr_neg;
  logic [OFF_W-1:0]   magx_d, magx_q, magy_d, magy_q;
  logic               negx_q, negy_q;
  logic               in_range;

  logic signed [31:0] x_coord, y_coord;

  // Configuration writes; the index covers exactly the four registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q  <= CENTER_COL_RST;
      center_row_q  <= CENTER_ROW_RST;
      inv_focal_x_q <= INV_FOCAL_X_RST;
      inv_focal_y_q <= INV_FOCAL_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_COL:  center_col_q  <= cfg_data_i[12:0];
        CFG_CENTER_ROW:  center_row_q  <= cfg_data_i[12:0];
        CFG_INV_FOCAL_X: inv_focal_x_q <= cfg_data_i;
        CFG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless the output beat is held by the receiver.
  assign pipe_en    = !(v_q[4] && out_stall_i);
  assign in_stall_o = skid_v_q;

  // A beat accepted while the pipeline holds parks in the skid register and
  // enters stage one ahead of any new beat.
  assign src   = skid_v_q ? skid_q : in_data_i;
  assign src_v = skid_v_q || in_valid_i;

  always_comb begin
    skid_v_d = skid_v_q;
    if (pipe_en) begin
      skid_v_d = 1'b0;
    end else if (in_valid_i && !skid_v_q) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pipe_en && in_valid_i && !skid_v_q) begin
      skid_q <= in_data_i;
    end
  end

  // Stage one: depth in metres and signed offsets from the principal point.
  assign z_num  = {src.depth_mm, 13'd0} + Z_BIAS;
  assign z_prod = ZP_W'(z_num) * ZP_W'(Z_RECIP);

  assign dc     = $signed({1'b0, src.column, 1'b0}) - $signed({1'b0, center_col_q});
  assign dr     = $signed({1'b0, src.pixel_row, 1'b0}) - $signed({1'b0, center_row_q});
  assign dc_neg = 14'(-dc);
  assign dr_neg = 14'(-dr);
  assign magx_d = dc[13] ? dc_neg[OFF_W-1:0] : dc[OFF_W-1:0];
  assign magy_d = dr[13] ? dr_neg[OFF_W-1:0] : dr[OFF_W-1:0];

  assign in_range = ({2'b00, src.column} < COL_LIMIT) &&
                    ({2'b00, src.pixel_row} < ROW_LIMIT);
  assign v_d      = src_v && (src.depth_mm != '0) && in_range;

  always_comb begin
    side_d.z     = z_prod[Z_SHIFT +: Z_W];
    side_d.blue  = src.blue;
    side_d.green = src.green;
    side_d.red   = src.red;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      v_q      <= '0;
    end else begin
      skid_v_q <= skid_v_d;
      if (pipe_en) begin
        v_q <= {v_q[3:0], v_d};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      magx_q    <= magx_d;
      magy_q    <= magy_d;
      negx_q    <= dc[13];
      // The row axis points down in the image, so y takes the opposite sign.
      negy_q    <= !dr[13];
      side_q[0] <= side_d;
      for (int i = 1; i < 5; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Stages two to five for each axis.
  dpbp_coord u_coord_x (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .off_mag_i (magx_q),
    .neg_i     (negx_q),
    .z_i       (side_q[0].z),
    .inv_i     (inv_focal_x_q),
    .coord_o   (x_coord)
  );

  dpbp_coord u_coord_y (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .off_mag_i (magy_q),
    .neg_i     (negy_q),
    .z_i       (side_q[0].z),
    .inv_i     (inv_focal_y_q),
    .coord_o   (y_coord)
  );

  assign out_valid_o = v_q[4];

  always_comb begin
    out_data_o.point_x   = x_coord;
    out_data_o.point_y   = y_coord;
    out_data_o.point_z   = side_q[4].z;
    out_data_o.blue_out  = side_q[4].blue;
    out_data_o.green_out = side_q[4].green;
    out_data_o.red_out   = side_q[4].red;
  end

endmodule

`default_nettype wire

[rtl/dpbp_checker.sv]
// Port-level assertions for the depth pixel back-projection block and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dpbp_checker import dpbp_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_stall_o,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input point_t out_data_o
);

  // A held output beat keeps its payload.
  `DPBP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // Only pixels with a nonzero depth produce a beat, so z is never zero.
  `DPBP_ASSERT(a_z_nonzero, !out_valid_o || (out_data_o.point_z != '0), "output beat with zero depth")

  // The input stalls only after the output was held in the cycle before.
  `DPBP_ASSERT(a_stall_cause, !$rose(in_stall_o) || $past(out_valid_o && out_stall_i), "input stall without output hold")

  // The skid register drains as soon as the pipeline moves again.
  `DPBP_ASSERT_NEXT(a_stall_clear, in_stall_o && !(out_valid_o && out_stall_i), !in_stall_o, "input stall outlived the hold")

endmodule

bind depth_pixel_back_projection dpbp_checker u_dpbp_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the depth pixel back-projection block.
`timescale 1ns / 1ps

module tb;
  import dpbp_pkg::*;

  // Cycles that a beat may still spend inside the block after the last
  // expected point has come out: five stages, one skid entry and some margin.
  localparam int unsigned PIPE_SLACK  = 8;
  // Far above the length of the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Nonzero-depth pixels sent in each random camera phase.
  localparam int unsigned PHASE_ITEMS = 136;
  localparam int unsigned N_PHASES    = 6;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_CAM,    // reprogram all four camera registers once the block is idle
    ROW_PIX,    // send a pixel, expectation from the predictor
    ROW_NONE,   // send a pixel that must give no point
    ROW_TYPED   // send a pixel whose point is written in the table
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    pixel_t      pix;
    point_t      pt;
    logic [31:0] ccol;
    logic [31:0] crow;
    logic [31:0] ifx;
    logic [31:0] ify;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  cfg_idx_e  cfg_index = CFG_CENTER_COL;
  logic [31:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  pixel_t    in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  point_t    out_data;

  // Our own copy of the camera registers, tracked at every write.
  logic [12:0] cam_ccol = CENTER_COL_RST;
  logic [12:0] cam_crow = CENTER_ROW_RST;
  logic [31:0] cam_ifx  = INV_FOCAL_X_RST;
  logic [31:0] cam_ify  = INV_FOCAL_Y_RST;

  // Points still owed by the block, oldest first.
  point_t    pending_points[$];
  stim_row_t stim_table[$];

  // Set while both sides run without any idling.
  bit          calm        = 1'b0;
  int unsigned err_count   = 0;
  int unsigned n_checked   = 0;
  int unsigned cycles      = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  point_t      want;

  depth_pixel_back_projection i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Projects one offset (in half pixels) through depth and a focal reciprocal.
  // The magnitude is rounded half up, the sign applied afterwards, so ties go
  // away from zero; the result then saturates to the signed 32-bit range.
  function automatic logic [31:0] project_axis(input logic signed [14:0] off,
                                               input logic [22:0] z,
                                               input logic [31:0] inv,
                                               input bit flip);
    logic        neg;
    logic [13:0] mag_off;
    logic [71:0] mag;
    neg     = (off < 0);
    mag_off = neg ? 14'(-off) : 14'(off);
    mag     = (72'(mag_off) * 72'(z) * 72'(inv) + (72'd1 << 32)) >> 33;
    if (flip) neg = !neg;
    if (mag == 0) return '0;
    if (!neg) return (mag > 72'(COORD_MAX)) ? COORD_MAX : mag[31:0];
    return (mag > 72'(COORD_MIN)) ? COORD_MIN : 32'(-mag[31:0]);
  endfunction

  // Returns 1 and the expected point when the pixel gives one.
  function automatic bit back_project(input pixel_t pix, output point_t pt);
    logic [32:0]        zfull;
    logic signed [14:0] dc;
    logic signed [14:0] dr;
    pt = '0;
    if (pix.depth_mm == 0) return 1'b0;
    if (32'(pix.column) >= MAX_COLUMNS || 32'(pix.pixel_row) >= MAX_ROWS) return 1'b0;
    zfull = (33'(pix.depth_mm) * 33'd65536 + 33'd500) / 33'd1000;
    dc = $signed({2'b00, pix.column, 1'b0}) - $signed({2'b00, cam_ccol});
    dr = $signed({2'b00, pix.pixel_row, 1'b0}) - $signed({2'b00, cam_crow});
    pt.point_x   = project_axis(dc, zfull[22:0], cam_ifx, 1'b0);
    pt.point_y   = project_axis(dr, zfull[22:0], cam_ify, 1'b1);
    pt.point_z   = zfull[22:0];
    pt.blue_out  = pix.blue;
    pt.green_out = pix.green;
    pt.red_out   = pix.red;
    return 1'b1;
  endfunction

  // Appends one row to the stimulus table.
  function automatic void append_row(input stim_row_t r);
    stim_table = {stim_table, r};
  endfunction

  // Appends one point to the list of points owed by the block.
  function automatic void owe_point(input point_t pt);
    pending_points = {pending_points, pt};
  endfunction

  function automatic void add_cam(input logic [31:0] ccol, input logic [31:0] crow,
                                  input logic [31:0] ifx, input logic [31:0] ify);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CAM;
    r.ccol = ccol;
    r.crow = crow;
    r.ifx  = ifx;
    r.ify  = ify;
    append_row(r);
  endfunction

  function automatic void add_pixel(input row_kind_e kind, input logic [15:0] depth,
                                    input logic [11:0] col, input logic [11:0] row,
                                    input logic [23:0] bgr, input logic [31:0] x,
                                    input logic [31:0] y, input logic [22:0] z);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.pix  = '{depth_mm: depth, column: col, pixel_row: row,
               blue: bgr[23:16], green: bgr[15:8], red: bgr[7:0]};
    r.pt   = '{point_x: x, point_y: y, point_z: z,
               blue_out: bgr[23:16], green_out: bgr[15:8], red_out: bgr[7:0]};
    append_row(r);
  endfunction

  // Offers one pixel beat, with a random idle gap in front unless calm is set,
  // and returns in the time step of the edge that accepted it. Valid is left
  // high on purpose so that a following beat can go out back to back.
  task automatic send_pixel(input pixel_t pix);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering beats and waits until every owed point has come out, then
  // lets the tail of the pipeline (zero-depth bubbles included) run empty.
  task automatic wait_points_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Writes all four camera registers on consecutive edges; call only when idle.
  task automatic program_camera(input logic [31:0] ccol, input logic [31:0] crow,
                                input logic [31:0] ifx, input logic [31:0] ify);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTER_COL;
    cfg_data  <= ccol;
    @(posedge clk);
    cfg_index <= CFG_CENTER_ROW;
    cfg_data  <= crow;
    @(posedge clk);
    cfg_index <= CFG_INV_FOCAL_X;
    cfg_data  <= ifx;
    @(posedge clk);
    cfg_index <= CFG_INV_FOCAL_Y;
    cfg_data  <= ify;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cam_ccol = ccol[12:0];
    cam_crow = crow[12:0];
    cam_ifx  = ifx;
    cam_ify  = ify;
  endtask

  // Receiving side: checks each accepted point beat against the oldest owed
  // point, and decides the stall for the next cycle. Once enough points have
  // been checked it holds off for a long stretch, so that the block fills up
  // and has to stall the sender, who keeps offering beats meanwhile.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still owed", cycles,
               pending_points.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall) begin
        if (pending_points.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected point beat %h", out_data);
        end else begin
          want = pending_points.pop_front();
          n_checked++;
          if (want.point_x !== out_data.point_x || want.point_y !== out_data.point_y ||
              want.point_z !== out_data.point_z || want.blue_out !== out_data.blue_out ||
              want.green_out !== out_data.green_out ||
              want.red_out !== out_data.red_out) begin
            err_count++;
            if (err_count <= 10)
              $display("point %0d mismatch: x %h/%h y %h/%h z %h/%h bgr %h%h%h/%h%h%h",
                       n_checked, want.point_x, out_data.point_x, want.point_y,
                       out_data.point_y, want.point_z, out_data.point_z, want.blue_out,
                       want.green_out, want.red_out, out_data.blue_out,
                       out_data.green_out, out_data.red_out);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && n_checked >= 400) begin
        hold_left = 100;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 22);
    end
  end

  // Sending side: directed table first, then random pixels under several
  // camera settings.
  initial begin
    pixel_t      pix;
    point_t      pt;
    logic [31:0] ccol;
    logic [31:0] crow;
    logic [31:0] ifx;
    logic [31:0] ify;
    int unsigned sent;

    // Rows before the first camera row run on the reset values of the registers.
    add_pixel(ROW_NONE,  16'd0,     12'd0,     12'd0,     24'h000000, '0, '0, '0);
    add_pixel(ROW_NONE,  16'd0,     12'hFFF,   12'hFFF,   24'hFFFFFF, '0, '0, '0);
    add_pixel(ROW_PIX,   16'd1,     12'd0,     12'd0,     24'h00FF00, '0, '0, '0);
    add_pixel(ROW_PIX,   16'hFFFF,  12'hFFF,   12'hFFF,   24'hFF00FF, '0, '0, '0);
    add_pixel(ROW_PIX,   16'hFFFF,  12'd0,     12'd0,     24'h123456, '0, '0, '0);
    add_pixel(ROW_PIX,   16'd1000,  12'd325,   12'd253,   24'h654321, '0, '0, '0);
    add_pixel(ROW_PIX,   16'd1000,  12'd326,   12'd254,   24'h0F0F0F, '0, '0, '0);
    add_pixel(ROW_PIX,   16'h8000,  12'h800,   12'h800,   24'hAA55AA, '0, '0, '0);
    add_pixel(ROW_PIX,   16'h5555,  12'hAAA,   12'h555,   24'h55AA55, '0, '0, '0);
    add_pixel(ROW_PIX,   16'hAAAA,  12'h555,   12'hAAA,   24'hF0F0F0, '0, '0, '0);
    // Principal point at the origin, largest reciprocals: pixel 0,0 has no
    // offset, the far corner saturates both coordinates.
    add_cam(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pixel(ROW_TYPED, 16'd1000,  12'd0,     12'd0,     24'h00FFAA, '0, '0, 23'd65536);
    add_pixel(ROW_TYPED, 16'hFFFF,  12'hFFF,   12'hFFF,   24'hFFFFFF,
              COORD_MAX, COORD_MIN, 23'd4294902);
    add_pixel(ROW_NONE,  16'd0,     12'hFFF,   12'd0,     24'h808080, '0, '0, '0);
    // Zero reciprocals force both coordinates to zero.
    add_cam(32'd8191, 32'd8191, 32'd0, 32'd0);
    add_pixel(ROW_TYPED, 16'hFFFF,  12'd0,     12'd0,     24'h010203, '0, '0, 23'd4294902);
    add_pixel(ROW_TYPED, 16'd1,     12'hFFF,   12'hFFF,   24'hFEFDFC, '0, '0, 23'd66);
    // Principal point at the far corner: pixel 0,0 saturates the other way.
    add_cam(32'd8191, 32'd8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pixel(ROW_TYPED, 16'hFFFF,  12'd0,     12'd0,     24'h7F807F,
              COORD_MIN, COORD_MAX, 23'd4294902);
    // Smallest nonzero reciprocals.
    add_cam(32'd1, 32'd1, 32'd1, 32'd1);
    add_pixel(ROW_PIX,   16'hFFFF,  12'hFFF,   12'hFFF,   24'h3C3C3C, '0, '0, '0);
    add_pixel(ROW_PIX,   16'd1,     12'd1,     12'd1,     24'hC3C3C3, '0, '0, '0);
    add_cam(32'(CENTER_COL_RST), 32'(CENTER_ROW_RST), INV_FOCAL_X_RST, INV_FOCAL_Y_RST);
    add_pixel(ROW_PIX,   16'd2000,  12'd640,   12'd480,   24'h9A5B2C, '0, '0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_CAM: begin
          wait_points_drained();
          program_camera(stim_table[i].ccol, stim_table[i].crow,
                         stim_table[i].ifx, stim_table[i].ify);
        end
        ROW_PIX: begin
          send_pixel(stim_table[i].pix);
          if (back_project(stim_table[i].pix, pt)) owe_point(pt);
        end
        ROW_NONE: send_pixel(stim_table[i].pix);
        default: begin
          send_pixel(stim_table[i].pix);
          owe_point(stim_table[i].pt);
        end
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_points_drained();
      ccol = $urandom_range(8191);
      crow = $urandom_range(8191);
      ifx  = 32'(64'd4294967296 / 64'($urandom_range(1500, 300)));
      ify  = 32'(64'd4294967296 / 64'($urandom_range(1500, 300)));
      case (ph)
        1: begin
          ccol = 32'd0;
          crow = 32'd8191;
          ifx  = $urandom;
          ify  = $urandom;
        end
        2: begin
          // Zero reciprocal on x only, tiny one on y.
          ccol = 32'd8191;
          crow = 32'd0;
          ifx  = 32'd0;
          ify  = $urandom_range(16, 1);
        end
        3: begin
          // Junk above the 13 register bits must be dropped by the block.
          ccol = $urandom;
          crow = $urandom;
          ifx  = $urandom;
          ify  = $urandom;
        end
        5: ifx = 32'hFFFF_FFFF;
        default: ;
      endcase
      program_camera(ccol, crow, ifx, ify);
      // One whole phase without idling on either side.
      calm = (ph == 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(3))
          0:       pix.depth_mm = $urandom_range(255, 1);
          1:       pix.depth_mm = $urandom_range(8000, 300);
          2:       pix.depth_mm = $urandom_range(65535, 1);
          default: pix.depth_mm = $urandom_range(1) ? 16'hFFFF : 16'd1;
        endcase
        if ($urandom_range(99) < 12) pix.depth_mm = '0;
        if ($urandom_range(3) == 0) begin
          // Near the principal point, where the offsets are small or zero.
          pix.column    = 12'((cam_ccol >> 1) + $urandom_range(8) - 4);
          pix.pixel_row = 12'((cam_crow >> 1) + $urandom_range(8) - 4);
        end else begin
          pix.column    = $urandom_range(4095);
          pix.pixel_row = $urandom_range(4095);
        end
        pix.blue  = $urandom_range(255);
        pix.green = $urandom_range(255);
        pix.red   = $urandom_range(255);
        send_pixel(pix);
        if (back_project(pix, pt)) owe_point(pt);
        if (pix.depth_mm != 0) begin
          sent++;
          // In phase 1 the sender pauses mid-phase until every owed point has come out.
          if (ph == 1 && sent == PHASE_ITEMS / 2) wait_points_drained();
        end
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    // Any stray beat still in the pipeline shows up as unexpected here.
    repeat (4 * PIPE_SLACK) @(posedge clk);
    if (err_count == 0 && pending_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/dpbp_pkg.sv
rtl/dpbp_coord.sv
rtl/depth_pixel_back_projection.sv
rtl/dpbp_checker.sv
tb/sv/tb.sv
